[design/pcl_pkg.sv]
// Shared types and constants for the pedestrian crossing light controller.
package pcl_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type CSR_CHANGE_DELAY   = 3'd0;
   localparam csr_index_type CSR_GREEN_HOLD     = 3'd1;
   localparam csr_index_type CSR_DISTANCE_LIMIT = 3'd2;
   localparam csr_index_type CSR_CROSS_BEATS    = 3'd3;
   localparam csr_index_type CSR_CROSS_HALF     = 3'd4;
   localparam csr_index_type CSR_BLINK_BEATS    = 3'd5;
   localparam csr_index_type CSR_BLINK_QUARTER  = 3'd6;

   localparam logic [15:0] RST_CHANGE_DELAY   = 16'd3000;
   localparam logic [15:0] RST_GREEN_HOLD     = 16'd5000;
   localparam logic [9:0]  RST_DISTANCE_LIMIT = 10'd20;
   localparam logic [4:0]  RST_CROSS_BEATS    = 5'd15;
   localparam logic [11:0] RST_CROSS_HALF     = 12'd500;
   localparam logic [3:0]  RST_BLINK_BEATS    = 4'd3;
   localparam logic [11:0] RST_BLINK_QUARTER  = 12'd250;

   // distance = echo * ECHO_SCALE / ECHO_DIVISOR, truncated
   localparam logic [3:0] ECHO_SCALE   = 4'd10;
   localparam logic [5:0] ECHO_DIVISOR = 6'd58;

   localparam logic [7:0] DUTY_SILENT = 8'd0;
   localparam logic [7:0] DUTY_CROSS  = 8'd40;
   localparam logic [7:0] DUTY_BLINK  = 8'd100;

   localparam logic [1:0] QUARTER_LAST = 2'd3;

   typedef enum logic [2:0] {
      PH_GREEN   = 3'd0,
      PH_CLOSING = 3'd1,
      PH_AMBER   = 3'd2,
      PH_CROSS   = 3'd3,
      PH_BLINK   = 3'd4
   } phase_type;

   typedef struct packed {
      logic        ped_button;
      logic        echo_valid;
      logic [15:0] echo_ticks;
   } pcl_req_type;

   typedef struct packed {
      logic       veh_red;
      logic       veh_amber;
      logic       veh_green;
      logic       ped_red;
      logic       ped_green;
      logic [7:0] beep_duty;
      logic [2:0] phase;
   } pcl_rsp_type;

   typedef struct packed {
      logic [15:0] change_delay_ms;
      logic [15:0] green_hold_ms;
      logic [9:0]  distance_limit_cm;
      logic [4:0]  cross_beats;
      logic [11:0] cross_half_ms;
      logic [3:0]  blink_beats;
      logic [11:0] blink_quarter_ms;
   } pcl_cfg_type;

endpackage

[design/pcl_csr_regs.sv]
// Configuration register file with write decode.
module pcl_csr_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  pcl_pkg::csr_index_type              csr_index,
   input  logic [pcl_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output pcl_pkg::pcl_cfg_type                cfg
);

   pcl_pkg::pcl_cfg_type cfg_ff;
   pcl_pkg::pcl_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            pcl_pkg::CSR_CHANGE_DELAY:   cfg_in.change_delay_ms   = csr_wdata;
            pcl_pkg::CSR_GREEN_HOLD:     cfg_in.green_hold_ms     = csr_wdata;
            pcl_pkg::CSR_DISTANCE_LIMIT: cfg_in.distance_limit_cm = csr_wdata[9:0];
            pcl_pkg::CSR_CROSS_BEATS:    cfg_in.cross_beats       = csr_wdata[4:0];
            pcl_pkg::CSR_CROSS_HALF:     cfg_in.cross_half_ms     = csr_wdata[11:0];
            pcl_pkg::CSR_BLINK_BEATS:    cfg_in.blink_beats       = csr_wdata[3:0];
            pcl_pkg::CSR_BLINK_QUARTER:  cfg_in.blink_quarter_ms  = csr_wdata[11:0];
            default: ;  // drop writes to unlisted indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.change_delay_ms   <= pcl_pkg::RST_CHANGE_DELAY;
         cfg_ff.green_hold_ms     <= pcl_pkg::RST_GREEN_HOLD;
         cfg_ff.distance_limit_cm <= pcl_pkg::RST_DISTANCE_LIMIT;
         cfg_ff.cross_beats       <= pcl_pkg::RST_CROSS_BEATS;
         cfg_ff.cross_half_ms     <= pcl_pkg::RST_CROSS_HALF;
         cfg_ff.blink_beats       <= pcl_pkg::RST_BLINK_BEATS;
         cfg_ff.blink_quarter_ms  <= pcl_pkg::RST_BLINK_QUARTER;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[design/pcl_request_detect.sv]
// Crossing request detection from the button and the echo distance.
module pcl_request_detect (
   input  pcl_pkg::pcl_req_type  req,
   input  logic [9:0]            distance_limit_cm,
   output logic                  request
);

   logic [19:0] echo_scaled;
   logic [15:0] echo_bound;
   logic        near;

   // floor(echo*10/58) <= limit  <=>  echo*10 <= 58*limit + 57
   assign echo_scaled = req.echo_ticks * pcl_pkg::ECHO_SCALE;
   assign echo_bound  = 16'({6'd0, distance_limit_cm} * {10'd0, pcl_pkg::ECHO_DIVISOR})
                        + 16'(pcl_pkg::ECHO_DIVISOR - 6'd1);
   assign near        = echo_scaled <= {4'd0, echo_bound};
   assign request     = req.ped_button || (req.echo_valid && near);

endmodule

[design/pcl_phase_seq.sv]
// Phase sequencer: phase, tick, beat and quarter counters plus lamp decode.
module pcl_phase_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  request,
   input  pcl_pkg::pcl_cfg_type  cfg,
   output pcl_pkg::pcl_rsp_type  rsp
);

   pcl_pkg::phase_type phase_ff, phase_in;
   logic [15:0] tick_ff, tick_in;
   logic [4:0]  beat_ff, beat_in;
   logic [1:0]  quarter_ff, quarter_in;
   logic        hold_ff, hold_in;

   logic [15:0] tick_next;
   logic [15:0] period_len;
   logic        period_done;
   logic [4:0]  beat_next;
   logic [4:0]  beat_limit;
   logic        beats_done;

   // Shared period counter: a zero length or a wrapped count ends the period.
   always_comb begin
      case (phase_ff)
         pcl_pkg::PH_CROSS: period_len = {4'd0, cfg.cross_half_ms};
         pcl_pkg::PH_BLINK: period_len = {4'd0, cfg.blink_quarter_ms};
         default:           period_len = cfg.change_delay_ms;
      endcase
      beat_limit = (phase_ff == pcl_pkg::PH_CROSS) ? cfg.cross_beats
                                                   : {1'b0, cfg.blink_beats};
   end

   assign tick_next   = tick_ff + 16'd1;
   assign period_done = (tick_next >= period_len) || (tick_next == 16'd0);
   assign beat_next   = beat_ff + 5'd1;
   assign beats_done  = (beat_next >= beat_limit) || (beat_next == 5'd0);

   // Next state
   always_comb begin
      phase_in   = phase_ff;
      tick_in    = tick_ff;
      beat_in    = beat_ff;
      quarter_in = quarter_ff;
      hold_in    = hold_ff;
      if (advance) begin
         unique case (phase_ff)
            pcl_pkg::PH_GREEN: begin
               if (hold_ff && (tick_ff < cfg.green_hold_ms)) begin
                  tick_in = tick_next;
               end else begin
                  tick_in = 16'd0;
                  hold_in = request;
                  if (request) begin
                     phase_in = pcl_pkg::PH_CLOSING;
                  end
               end
            end
            pcl_pkg::PH_CLOSING: begin
               tick_in = period_done ? 16'd0 : tick_next;
               if (period_done) begin
                  phase_in = pcl_pkg::PH_AMBER;
               end
            end
            pcl_pkg::PH_AMBER: begin
               tick_in = period_done ? 16'd0 : tick_next;
               if (period_done) begin
                  phase_in   = pcl_pkg::PH_CROSS;
                  beat_in    = 5'd0;
                  quarter_in = 2'd0;
               end
            end
            pcl_pkg::PH_CROSS: begin
               tick_in = period_done ? 16'd0 : tick_next;
               if (period_done) begin
                  if (!quarter_ff[0]) begin
                     quarter_in = 2'd1;
                  end else begin
                     quarter_in = 2'd0;
                     beat_in    = beats_done ? 5'd0 : beat_next;
                     if (beats_done) begin
                        phase_in = pcl_pkg::PH_BLINK;
                     end
                  end
               end
            end
            pcl_pkg::PH_BLINK: begin
               tick_in = period_done ? 16'd0 : tick_next;
               if (period_done) begin
                  quarter_in = quarter_ff + 2'd1;
                  if (quarter_ff == pcl_pkg::QUARTER_LAST) begin
                     beat_in = beats_done ? 5'd0 : beat_next;
                     if (beats_done) begin
                        phase_in = pcl_pkg::PH_GREEN;
                     end
                  end
               end
            end
            default: begin
               phase_in = pcl_pkg::PH_GREEN;
            end
         endcase
      end
   end

   // Outputs from the state before this transaction's update
   always_comb begin
      rsp           = '0;
      rsp.phase     = phase_ff;
      rsp.beep_duty = pcl_pkg::DUTY_SILENT;
      unique case (phase_ff)
         pcl_pkg::PH_GREEN, pcl_pkg::PH_CLOSING: begin
            rsp.veh_green = 1'b1;
            rsp.ped_red   = 1'b1;
         end
         pcl_pkg::PH_AMBER: begin
            rsp.veh_amber = 1'b1;
            rsp.ped_red   = 1'b1;
         end
         pcl_pkg::PH_CROSS: begin
            rsp.veh_red   = 1'b1;
            rsp.ped_green = 1'b1;
            if (!quarter_ff[0]) begin
               rsp.beep_duty = pcl_pkg::DUTY_CROSS;
            end
         end
         pcl_pkg::PH_BLINK: begin
            rsp.veh_red   = 1'b1;
            rsp.ped_green = quarter_ff[1];
            if (!quarter_ff[0]) begin
               rsp.beep_duty = pcl_pkg::DUTY_BLINK;
            end
         end
         default: begin
            rsp.veh_red = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= pcl_pkg::PH_GREEN;
         tick_ff    <= 16'd0;
         beat_ff    <= 5'd0;
         quarter_ff <= 2'd0;
         hold_ff    <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         tick_ff    <= tick_in;
         beat_ff    <= beat_in;
         quarter_ff <= quarter_in;
         hold_ff    <= hold_in;
      end
   end

endmodule

[design/pedestrian_crossing_light_controller_unit.sv]
// Top level of the pedestrian crossing light controller.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  pcl_req_type (one millisecond tick)
//   rsp      out        rsp_valid / rsp_stall  pcl_rsp_type (lamps, duty, phase)
//   csr      in         csr_write_enable       csr_index, csr_wdata (no read-back)
//
// One transaction per cycle while the result side is not stalled; each tick
// passes through the input register and then the result register.
// The phase/counter state advances as each tick moves into the result register.
// Synchronous active-high reset clears the phase state and loads the register
// defaults; no clearing pass. A stalled result holds in the result register
// while one more tick waits in the input register.
module pedestrian_crossing_light_controller_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  pcl_pkg::pcl_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output pcl_pkg::pcl_rsp_type                rsp_data,
   input  logic                                csr_write_enable,
   input  pcl_pkg::csr_index_type              csr_index,
   input  logic [pcl_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic                  in_valid_ff, in_valid_in;
   pcl_pkg::pcl_req_type  in_data_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   pcl_pkg::pcl_rsp_type  rsp_data_ff;

   pcl_pkg::pcl_cfg_type  cfg;
   pcl_pkg::pcl_rsp_type  seq_rsp;
   logic                  request;
   logic                  fire;
   logic                  accept;

   assign fire      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   pcl_csr_regs u_csr_regs (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   pcl_request_detect u_request_detect (
      .req               (in_data_ff),
      .distance_limit_cm (cfg.distance_limit_cm),
      .request           (request)
   );

   pcl_phase_seq u_phase_seq (
      .clock   (clock),
      .reset   (reset),
      .advance (fire),
      .request (request),
      .cfg     (cfg),
      .rsp     (seq_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: load on handshake, hold otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= seq_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[dv/pcl_checker.sv]
`timescale 1ns / 1ps
// Lamp sequence predictor and result checker for the pedestrian crossing light controller.
module pcl_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  pcl_pkg::pcl_req_type                req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  pcl_pkg::pcl_rsp_type                rsp_data,
   input  logic                                csr_write_enable,
   input  pcl_pkg::csr_index_type              csr_index,
   input  logic [pcl_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                                  mismatch_count,
   output int                                  outstanding,
   output int                                  checked_count
);
   import pcl_pkg::*;

   localparam int PRINT_CAP = 100;

   pcl_cfg_type settings;
   phase_type   light_phase;
   logic [15:0] tick_cnt;
   logic [4:0]  beat_cnt;
   logic [1:0]  quarter;
   logic        hold_pending;
   pcl_rsp_type lamps_due[$];

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) begin
         $display("[%0t] lamp check: %s", $realtime, msg);
      end
   endtask

   task automatic compare_field(input string name, input logic [7:0] got,
                                input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d %s got %0d, expected %0d",
                                   checked_count, name, got, want));
      end
   endtask

   // Advance the shared tick counter; true when a period of len ticks has ended.
   function automatic logic period_elapsed(input logic [15:0] len);
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= len || tick_cnt == 16'd0) begin
         tick_cnt = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Lamps come from the state before the tick, then the sequencer advances.
   function automatic pcl_rsp_type advance_lights(input pcl_req_type tick);
      pcl_rsp_type lamps;
      int unsigned distance_cm;
      lamps = '0;
      case (light_phase)
         PH_GREEN, PH_CLOSING: begin
            lamps.veh_green = 1'b1;
            lamps.ped_red   = 1'b1;
         end
         PH_AMBER: begin
            lamps.veh_amber = 1'b1;
            lamps.ped_red   = 1'b1;
         end
         PH_CROSS: begin
            lamps.veh_red   = 1'b1;
            lamps.ped_green = 1'b1;
            lamps.beep_duty = quarter[0] ? DUTY_SILENT : DUTY_CROSS;
         end
         default: begin
            lamps.veh_red   = 1'b1;
            lamps.ped_green = quarter[1];
            lamps.beep_duty = quarter[0] ? DUTY_SILENT : DUTY_BLINK;
         end
      endcase
      lamps.phase = light_phase;

      case (light_phase)
         PH_GREEN: begin
            if (hold_pending && tick_cnt < settings.green_hold_ms) begin
               tick_cnt = tick_cnt + 16'd1;
            end else begin
               distance_cm  = (32'(tick.echo_ticks) * ECHO_SCALE) / ECHO_DIVISOR;
               hold_pending = 1'b0;
               tick_cnt     = '0;
               if (tick.ped_button ||
                   (tick.echo_valid && distance_cm <= settings.distance_limit_cm)) begin
                  hold_pending = 1'b1;
                  light_phase  = PH_CLOSING;
               end
            end
         end
         PH_CLOSING: begin
            if (period_elapsed(settings.change_delay_ms)) light_phase = PH_AMBER;
         end
         PH_AMBER: begin
            if (period_elapsed(settings.change_delay_ms)) begin
               light_phase = PH_CROSS;
               beat_cnt    = '0;
               quarter     = '0;
            end
         end
         PH_CROSS: begin
            if (period_elapsed({4'd0, settings.cross_half_ms})) begin
               if (!quarter[0]) begin
                  quarter = 2'd1;
               end else begin
                  quarter  = '0;
                  beat_cnt = beat_cnt + 5'd1;
                  if (beat_cnt >= settings.cross_beats || beat_cnt == 5'd0) begin
                     light_phase = PH_BLINK;
                     beat_cnt    = '0;
                  end
               end
            end
         end
         default: begin
            if (period_elapsed({4'd0, settings.blink_quarter_ms})) begin
               if (quarter == QUARTER_LAST) begin
                  quarter  = '0;
                  beat_cnt = beat_cnt + 5'd1;
                  if (beat_cnt >= {1'b0, settings.blink_beats} || beat_cnt == 5'd0) begin
                     light_phase = PH_GREEN;
                     beat_cnt    = '0;
                     tick_cnt    = '0;
                  end
               end else begin
                  quarter = quarter + 2'd1;
               end
            end
         end
      endcase
      return lamps;
   endfunction

   always @(posedge clock) begin
      pcl_rsp_type want;
      if (reset) begin
         settings.change_delay_ms   = RST_CHANGE_DELAY;
         settings.green_hold_ms     = RST_GREEN_HOLD;
         settings.distance_limit_cm = RST_DISTANCE_LIMIT;
         settings.cross_beats       = RST_CROSS_BEATS;
         settings.cross_half_ms     = RST_CROSS_HALF;
         settings.blink_beats       = RST_BLINK_BEATS;
         settings.blink_quarter_ms  = RST_BLINK_QUARTER;
         light_phase  = PH_GREEN;
         tick_cnt     = '0;
         beat_cnt     = '0;
         quarter      = '0;
         hold_pending = 1'b0;
         lamps_due.delete();
         outstanding = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_CHANGE_DELAY:   settings.change_delay_ms   = csr_wdata;
               CSR_GREEN_HOLD:     settings.green_hold_ms     = csr_wdata;
               CSR_DISTANCE_LIMIT: settings.distance_limit_cm = 10'(csr_wdata);
               CSR_CROSS_BEATS:    settings.cross_beats       = 5'(csr_wdata);
               CSR_CROSS_HALF:     settings.cross_half_ms     = 12'(csr_wdata);
               CSR_BLINK_BEATS:    settings.blink_beats       = 4'(csr_wdata);
               CSR_BLINK_QUARTER:  settings.blink_quarter_ms  = 12'(csr_wdata);
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (lamps_due.size() == 0) begin
               report_mismatch($sformatf("result with no tick outstanding, phase %0d",
                                         rsp_data.phase));
            end else begin
               want = lamps_due.pop_front();
               checked_count++;
               compare_field("veh_red",   rsp_data.veh_red,   want.veh_red);
               compare_field("veh_amber", rsp_data.veh_amber, want.veh_amber);
               compare_field("veh_green", rsp_data.veh_green, want.veh_green);
               compare_field("ped_red",   rsp_data.ped_red,   want.ped_red);
               compare_field("ped_green", rsp_data.ped_green, want.ped_green);
               compare_field("beep_duty", rsp_data.beep_duty, want.beep_duty);
               compare_field("phase",     rsp_data.phase,     want.phase);
            end
         end
         if (req_valid && !req_stall) lamps_due.push_back(advance_lights(req_data));
         outstanding = lamps_due.size();
      end
   end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// Stimulus and verdict for the pedestrian crossing light controller.
module tb;
   import pcl_pkg::*;

   localparam int CLOCK_PERIOD  = 20;
   localparam int RESET_CYCLES  = 3;
   localparam int TIMEOUT_NS    = 10_000_000;
   localparam int FULL_SCALE_TICKS = 150;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_TICKS   = 200;
   localparam int SETTLE_CYCLES = 8;

   localparam csr_index_type CSR_UNLISTED = 3'd7;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   pcl_req_type               req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   pcl_rsp_type               rsp_data;
   logic                      csr_write_enable = 1'b0;
   csr_index_type             csr_index = CSR_CHANGE_DELAY;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   int mismatch_count;
   int outstanding;
   int checked_count;

   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   int          ticks_sent = 0;
   int          settings_count = 0;
   pcl_cfg_type settings;

   pedestrian_crossing_light_controller_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   pcl_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding),
      .checked_count    (checked_count)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_SENDER: begin
            sender_idle_pct    = 75;
            receiver_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 75;
         end
         IDLE_BOTH: begin
            sender_idle_pct    = 25;
            receiver_stall_pct = 25;
         end
         default: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
      endcase
   endtask

   task automatic send_tick(input pcl_req_type tick);
      int gap;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= tick;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ticks_sent++;
   endtask

   // Hold the sender until every tick in flight has produced its lamps.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Narrow registers get junk above their width to exercise the masking.
   task automatic write_settings(input pcl_cfg_type c);
      logic [CSR_DATA_WIDTH-1:0] word [8];
      word[CSR_CHANGE_DELAY]   = c.change_delay_ms;
      word[CSR_GREEN_HOLD]     = c.green_hold_ms;
      word[CSR_DISTANCE_LIMIT] = {6'($urandom), c.distance_limit_cm};
      word[CSR_CROSS_BEATS]    = {11'($urandom), c.cross_beats};
      word[CSR_CROSS_HALF]     = {4'($urandom), c.cross_half_ms};
      word[CSR_BLINK_BEATS]    = {12'($urandom), c.blink_beats};
      word[CSR_BLINK_QUARTER]  = {4'($urandom), c.blink_quarter_ms};
      word[CSR_UNLISTED]       = 16'($urandom);
      for (int i = 0; i < 8; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= csr_index_type'(i);
         csr_wdata        <= word[i];
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      settings = c;
      settings_count++;
   endtask

   // Short timings so that whole crossing cycles fit in a phase.
   function automatic pcl_cfg_type random_settings();
      pcl_cfg_type c;
      c.change_delay_ms   = 16'($urandom_range(6));
      c.green_hold_ms     = 16'($urandom_range(8));
      c.distance_limit_cm = 10'($urandom_range(1023));
      c.cross_beats       = ($urandom_range(7) == 0) ? 5'($urandom_range(31))
                                                      : 5'($urandom_range(4));
      c.cross_half_ms     = 12'($urandom_range(4));
      c.blink_beats       = ($urandom_range(7) == 0) ? 4'($urandom_range(15))
                                                      : 4'($urandom_range(3));
      c.blink_quarter_ms  = 12'($urandom_range(3));
      return c;
   endfunction

   // Mostly echoes close to the current limit, the rest anywhere in range.
   function automatic pcl_req_type random_tick();
      pcl_req_type t;
      int near_echo;
      t.ped_button = ($urandom_range(9) == 0);
      t.echo_valid = 1'($urandom_range(1));
      if ($urandom_range(2) == 0) begin
         t.echo_ticks = 16'($urandom);
      end else begin
         near_echo = (int'(settings.distance_limit_cm) * ECHO_DIVISOR) / ECHO_SCALE
                     + int'($urandom_range(12)) - 6;
         if (near_echo < 0) near_echo = 0;
         t.echo_ticks = 16'(near_echo);
      end
      return t;
   endfunction

   initial begin
      #(TIMEOUT_NS);
      $display("pedestrian_crossing_light_controller_unit: mismatch");
      $finish;
   end

   initial begin
      pcl_req_type tick;
      int          pause_at;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      set_idling(IDLE_NONE);

      // Reset defaults: far echo, stale echo, then an echo of exactly 20 cm.
      send_tick('{ped_button: 1'b0, echo_valid: 1'b1, echo_ticks: 16'hFFFF});
      send_tick('{ped_button: 1'b0, echo_valid: 1'b0, echo_ticks: 16'h0000});
      send_tick('{ped_button: 1'b0, echo_valid: 1'b1, echo_ticks: 16'd116});
      drain_results();

      // Every timing at its floor and a zero distance limit.
      write_settings('0);
      for (int k = 0; k < 16; k++) begin
         tick.ped_button = (k % 5 == 4);
         tick.echo_valid = k[0];
         tick.echo_ticks = k[1] ? 16'hFFFF : (k[2] ? 16'd6 : 16'd0);
         send_tick(tick);
      end
      drain_results();

      write_settings('1);
      for (int k = 0; k < FULL_SCALE_TICKS; k++) send_tick(random_tick());
      drain_results();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_settings(random_settings());
         set_idling(idle_mode_type'(p % 4));
         pause_at = $urandom_range(PHASE_TICKS - 1);
         for (int k = 0; k < PHASE_TICKS; k++) begin
            if (k == pause_at) drain_results();
            send_tick(random_tick());
         end
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d ticks over %0d register settings: floor and full-scale timings,",
               ticks_sent, settings_count);
      $display("random short cycles under four idling patterns; %0d results compared",
               checked_count);
      if (mismatch_count == 0) begin
         $display("pedestrian_crossing_light_controller_unit: match");
      end else begin
         $display("pedestrian_crossing_light_controller_unit: mismatch");
      end
      $finish;
   end

endmodule

[filelist.f]
design/pcl_pkg.sv
design/pcl_csr_regs.sv
design/pcl_request_detect.sv
design/pcl_phase_seq.sv
design/pedestrian_crossing_light_controller_unit.sv
dv/pcl_checker.sv
dv/tb.sv
